/* src/tile_map_ray_caster_defines.svh */
// Assertion macros shared by the ray caster modules.
// Each module that uses them has ports named clk and rst_n.
`ifndef TILE_MAP_RAY_CASTER_DEFINES_SVH
`define TILE_MAP_RAY_CASTER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define TMRC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tile map ray caster check failed");

// Checked on every rising edge, reset included.
`define TMRC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("tile map ray caster check failed");

`endif

/* src/tmrc_pkg.sv */
`default_nettype none
package tmrc_pkg;

    localparam int POS_W   = 23;
    localparam int STEP_W  = 12;
    localparam int COS_W   = 16;
    localparam int COS_FRAC = 15;
    localparam int HH_W    = 11;
    localparam int VH_W    = 12;
    localparam int TW_W    = 11;
    localparam int WH_W    = 12;
    localparam int TEX_W   = 10;
    localparam int CNT_OUT_W = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic       CMD_WRITE_TILE = 1'b0;
    localparam logic       CMD_CAST_RAY   = 1'b1;
    localparam logic [3:0] WALL_CODE      = 4'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH = 3'd4;

    localparam logic [POS_W-1:0] VIEWER_RESET = 23'd131072;
    localparam logic [HH_W-1:0]  HH_RESET     = 11'd135;
    localparam logic [VH_W-1:0]  VH_RESET     = 12'd270;
    localparam logic [TW_W-1:0]  TW_RESET     = 11'd64;

    localparam logic [POS_W-1:0] POS_MAX   = 23'h3FFFFF;
    localparam logic [POS_W-1:0] POS_MIN   = 23'h400000;
    localparam logic [15:0]      FRAC_LOW  = 16'd655;
    localparam logic [15:0]      FRAC_HIGH = 16'd64881;
    localparam logic [WH_W-1:0]  WH_MAX    = 12'hFFF;
    localparam logic [TEX_W-1:0] TEX_MAX   = 10'h3FF;

    typedef struct packed {
        logic write_tile;
        logic capture;
        logic advance;
        logic mult;
        logic div_step;
        logic finish;
    } tmrc_cmd_t;

    typedef struct packed {
        logic stop;
    } tmrc_status_t;

endpackage
`default_nettype wire

/* src/tmrc_ram.sv */
`default_nettype none
module tmrc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* src/tmrc_ctrl.sv */
`default_nettype none
`include "tile_map_ray_caster_defines.svh"
module tmrc_ctrl
    import tmrc_pkg::*;
#(
    parameter int DIV_STEPS = 33
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire logic   command,
    input  tmrc_status_t status,
    output tmrc_cmd_t   cmd,
    output logic        busy,
    output logic        done
);

    localparam int CW = $clog2(DIV_STEPS + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_INIT   = 6'b000010,
        ST_MARCH  = 6'b000100,
        ST_MULT   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] div_cnt_reg, div_cnt_next;
    logic          done_reg, done_next;
    logic          accept;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign accept = start && !busy;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        done_next    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_CAST_RAY))
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_INIT;
                end
                else if (accept)
                begin
                    cmd.write_tile = 1'b1;
                end
            end
            ST_INIT:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_MARCH;
            end
            ST_MARCH:
            begin
                if (status.stop)
                begin
                    state_next = ST_MULT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_MULT:
            begin
                cmd.mult     = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            done_reg    <= done_next;
        end
    end

    `TMRC_ASSERT(a_cast_starts_march,
        (accept && (command == CMD_CAST_RAY)) |=> (state_reg == ST_INIT))
    `TMRC_ASSERT(a_finish_after_div, (state_reg == ST_FINISH) |-> ($past(state_reg) == ST_DIV))
    `TMRC_ASSERT_ALWAYS(a_div_count_bound,
        (state_reg != ST_DIV) || (div_cnt_reg < CW'(DIV_STEPS)))

endmodule
`default_nettype wire

/* src/tmrc_datapath.sv */
`default_nettype none
`include "tile_map_ray_caster_defines.svh"
module tmrc_datapath
    import tmrc_pkg::*;
#(
    parameter int MAP_SIZE       = 64,
    parameter int STEPS_PER_TILE = 64,
    parameter int MAX_STEPS      = 8191
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  tmrc_cmd_t                  cmd,
    output tmrc_status_t               status,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [POS_W-1:0]      cfg_data,
    input  wire logic [5:0]            tile_col,
    input  wire logic [5:0]            tile_row,
    input  wire logic [3:0]            tile_code,
    input  wire logic [STEP_W-1:0]     step_x,
    input  wire logic [STEP_W-1:0]     step_y,
    input  wire logic [COS_W-1:0]      view_cos,
    output logic      [WH_W-1:0]       wall_height,
    output logic      [VH_W-1:0]       wall_top,
    output logic      [VH_W-1:0]       wall_bottom,
    output logic      [TEX_W-1:0]      texture_column,
    output logic      [POS_W-1:0]      hit_x,
    output logic      [POS_W-1:0]      hit_y,
    output logic      [CNT_OUT_W-1:0]  step_total
);

    localparam int DEPTH  = MAP_SIZE * MAP_SIZE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam int DEN_W  = CNT_W + COS_W;
    localparam int SPT_W  = $clog2(STEPS_PER_TILE + 1);
    localparam int HS_W   = HH_W + SPT_W;
    localparam int NUM_W  = HS_W + COS_FRAC;
    localparam int TP_W   = 16 + TW_W;

    logic [POS_W-1:0]  viewer_x_reg, viewer_y_reg;
    logic [HH_W-1:0]   hh_reg;
    logic [VH_W-1:0]   vh_reg;
    logic [TW_W-1:0]   tw_reg;

    logic [STEP_W-1:0] step_x_reg, step_y_reg;
    logic [COS_W-1:0]  cos_reg;
    logic [POS_W-1:0]  pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic [CNT_W-1:0]  count_reg;
    logic              inside_reg;

    logic [DEN_W-1:0]  den_reg, rem_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [TP_W-1:0]   tex_prod_reg;

    logic [AW-1:0]     waddr, raddr;
    logic              wr_inside, rd_inside;
    logic [3:0]        rdata;
    logic [5:0]        tx, ty;
    logic              in_x, in_y;

    logic [DEN_W:0]    shifted, diff;
    logic              ge;
    logic [HS_W-1:0]   hh_scaled;
    logic [15:0]       frac_sel;
    logic [WH_W-1:0]   wh;
    logic [VH_W:0]     bot_sum;
    logic [TW_W-1:0]   tex_raw, tex_lim;

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] p,
                                                 input logic [STEP_W-1:0] s);
        logic [POS_W:0] sum;
        sum = {p[POS_W-1], p} + {{(POS_W + 1 - STEP_W){s[STEP_W-1]}}, s};
        if (sum[POS_W] != sum[POS_W-1])
        begin
            sat_add = sum[POS_W] ? POS_MIN : POS_MAX;
        end
        else
        begin
            sat_add = sum[POS_W-1:0];
        end
    endfunction

    function automatic logic tile_ok(input logic [POS_W-1:0] p);
        logic neg_zero;
        neg_zero = (p[POS_W-1:16] == '1) && (p[15:0] != '0);
        tile_ok  = neg_zero || (!p[POS_W-1] && (int'(p[POS_W-1:16]) < MAP_SIZE));
    endfunction

    assign pos_x_next = sat_add(pos_x_reg, step_x_reg);
    assign pos_y_next = sat_add(pos_y_reg, step_y_reg);
    assign in_x       = tile_ok(pos_x_next);
    assign in_y       = tile_ok(pos_y_next);
    assign tx         = pos_x_next[POS_W-1] ? 6'd0 : pos_x_next[21:16];
    assign ty         = pos_y_next[POS_W-1] ? 6'd0 : pos_y_next[21:16];
    assign rd_inside  = in_x && in_y;
    assign raddr      = AW'(int'(ty) * MAP_SIZE + int'(tx));
    assign waddr      = AW'(int'(tile_row) * MAP_SIZE + int'(tile_col));
    assign wr_inside  = (int'(tile_col) < MAP_SIZE) && (int'(tile_row) < MAP_SIZE);

    tmrc_ram #(
        .WIDTH (4),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (cmd.write_tile && wr_inside),
        .waddr (waddr),
        .wdata (tile_code),
        .re    (cmd.advance),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.stop = !inside_reg || (rdata == WALL_CODE)
                         || (count_reg == CNT_W'(MAX_STEPS));

    assign shifted   = {rem_reg, q_reg[NUM_W-1]};
    assign ge        = shifted >= {1'b0, den_reg};
    assign diff      = shifted - {1'b0, den_reg};
    assign hh_scaled = HS_W'(hh_reg) * HS_W'(STEPS_PER_TILE);
    assign frac_sel  = ((pos_x_reg[15:0] <= FRAC_LOW) || (pos_x_reg[15:0] >= FRAC_HIGH))
                       ? pos_y_reg[15:0] : pos_x_reg[15:0];

    assign wh      = (|q_reg[NUM_W-1:WH_W]) ? WH_MAX : q_reg[WH_W-1:0];
    assign bot_sum = {2'b00, hh_reg} + {1'b0, wh};
    assign tex_raw = tex_prod_reg[TP_W-1:16];

    always_comb
    begin
        if (tw_reg == '0)
        begin
            tex_lim = '0;
        end
        else if (tex_raw > (tw_reg - 1'b1))
        begin
            tex_lim = tw_reg - 1'b1;
        end
        else
        begin
            tex_lim = tex_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viewer_x_reg <= VIEWER_RESET;
            viewer_y_reg <= VIEWER_RESET;
            hh_reg       <= HH_RESET;
            vh_reg       <= VH_RESET;
            tw_reg       <= TW_RESET;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            count_reg    <= '0;
            inside_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_VIEWER_X:      viewer_x_reg <= cfg_data;
                    CFG_VIEWER_Y:      viewer_y_reg <= cfg_data;
                    CFG_HALF_HEIGHT:   hh_reg       <= cfg_data[HH_W-1:0];
                    CFG_VIEW_HEIGHT:   vh_reg       <= cfg_data[VH_W-1:0];
                    CFG_TEXTURE_WIDTH: tw_reg       <= cfg_data[TW_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.capture)
            begin
                pos_x_reg <= viewer_x_reg;
                pos_y_reg <= viewer_y_reg;
                count_reg <= '0;
            end
            else if (cmd.advance)
            begin
                pos_x_reg  <= pos_x_next;
                pos_y_reg  <= pos_y_next;
                count_reg  <= count_reg + 1'b1;
                inside_reg <= rd_inside;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            step_x_reg <= step_x;
            step_y_reg <= step_y;
            cos_reg    <= view_cos;
        end
        if (cmd.mult)
        begin
            den_reg      <= DEN_W'(count_reg) * DEN_W'(cos_reg);
            q_reg        <= {hh_scaled, {COS_FRAC{1'b0}}};
            rem_reg      <= '0;
            tex_prod_reg <= TP_W'(frac_sel) * TP_W'(tw_reg);
        end
        if (cmd.div_step)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
        if (cmd.finish)
        begin
            wall_height    <= wh;
            wall_top       <= ({1'b0, hh_reg} <= wh) ? '0 : ({1'b0, hh_reg} - wh);
            wall_bottom    <= (bot_sum > {1'b0, vh_reg}) ? vh_reg : bot_sum[VH_W-1:0];
            texture_column <= (tex_lim > TW_W'(TEX_MAX)) ? TEX_MAX : tex_lim[TEX_W-1:0];
            hit_x          <= pos_x_reg;
            hit_y          <= pos_y_reg;
            step_total     <= CNT_OUT_W'(count_reg);
        end
    end

    `TMRC_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_STEPS))
    `TMRC_ASSERT(a_no_step_past_limit, cmd.advance |-> (count_reg != CNT_W'(MAX_STEPS)))
    `TMRC_ASSERT(a_div_remainder,
        cmd.div_step |-> ((den_reg == '0) || (rem_reg < den_reg)))

endmodule
`default_nettype wire

/* src/tile_map_ray_caster.sv */
`default_nettype none
// Tile map ray caster.
// Commands enter on start while busy is low. A tile write (command 0) stores
// tile_code at tile_col, tile_row and gives no result; the next
// command may follow in the next cycle. A ray cast (command 1) marches from
// the viewer position by step_x, step_y until a wall tile, the map edge or the
// step limit, then divides to get the wall height.
// The march runs one step per cycle, limited by the registered map read.
// The divider retires one quotient bit per cycle and produces
// 11 + clog2(STEPS_PER_TILE+1) + 15 quotient bits (33 by default).
// A cast runs through the states INIT, MARCH, MULT, DIV and FINISH and then
// shows its result on done; busy is high while these states run.
// done is high for exactly one cycle and the receiver cannot stall it: the
// result ports hold their values until the next cast finishes.
// Configuration writes are taken on cfg_valid at any time (cfg_ready is
// always high) and must only be made while the block is idle.
// Reset loads the register defaults and returns to idle. The map is not
// cleared; a tile must be written before a ray can read it.
module tile_map_ray_caster
    import tmrc_pkg::*;
#(
    parameter int MAP_SIZE       = 64,
    parameter int STEPS_PER_TILE = 64,
    parameter int MAX_STEPS      = 8191
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  command,
    input  wire logic [5:0]            tile_col,
    input  wire logic [5:0]            tile_row,
    input  wire logic [3:0]            tile_code,
    input  wire logic [STEP_W-1:0]     step_x,
    input  wire logic [STEP_W-1:0]     step_y,
    input  wire logic [COS_W-1:0]      view_cos,
    output logic                       done,
    output logic      [WH_W-1:0]       wall_height,
    output logic      [VH_W-1:0]       wall_top,
    output logic      [VH_W-1:0]       wall_bottom,
    output logic      [TEX_W-1:0]      texture_column,
    output logic      [POS_W-1:0]      hit_x,
    output logic      [POS_W-1:0]      hit_y,
    output logic      [CNT_OUT_W-1:0]  step_total,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [POS_W-1:0]      cfg_data
);

    localparam int DIV_STEPS = HH_W + $clog2(STEPS_PER_TILE + 1) + COS_FRAC;

    tmrc_cmd_t    cmd;
    tmrc_status_t status;

    assign cfg_ready = 1'b1;

    tmrc_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    tmrc_datapath #(
        .MAP_SIZE       (MAP_SIZE),
        .STEPS_PER_TILE (STEPS_PER_TILE),
        .MAX_STEPS      (MAX_STEPS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .tile_col       (tile_col),
        .tile_row       (tile_row),
        .tile_code      (tile_code),
        .step_x         (step_x),
        .step_y         (step_y),
        .view_cos       (view_cos),
        .wall_height    (wall_height),
        .wall_top       (wall_top),
        .wall_bottom    (wall_bottom),
        .texture_column (texture_column),
        .hit_x          (hit_x),
        .hit_y          (hit_y),
        .step_total     (step_total)
    );

endmodule
`default_nettype wire
